/* hdl/window_variance_motion_detector_unit_defines.svh */
// Assertion macros shared by the motion detector RTL.
// Has no dependencies; included by files that carry concurrent assertions.
`ifndef WINDOW_VARIANCE_MOTION_DETECTOR_UNIT_DEFINES_SVH
`define WINDOW_VARIANCE_MOTION_DETECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define WVMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("motion detector assertion failed");
// Implication checked in the next cycle.
`define WVMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("motion detector assertion failed");
`else
`define WVMD_ASSERT_IMP(label, clk, rst, ante, cons)
`define WVMD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/wvmd_pkg.sv */
// Shared constants and types of the window variance motion detector.
// Has no dependencies; imported by every module of the block.
package wvmd_pkg;

   localparam int SAMPLE_BITS      = 16;
   localparam int THRESH_BITS      = 31;
   localparam int VAR_BITS         = 31;
   localparam int WINDOW_LOG2_DEF  = 7;
   localparam int MID_DEPTH        = 4;
   localparam int OUT_DEPTH        = 8;
   localparam int MID_CNT_BITS     = $clog2(MID_DEPTH + 1);
   localparam int OUT_CNT_BITS     = $clog2(OUT_DEPTH + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // One accepted sample as handed from the front to the statistics pipeline.
   typedef struct packed {
      sample_type sample;
      sample_type old_sample;
      logic       full;
   } item_type;

   typedef struct packed {
      logic                window_full;
      logic                moving;
      logic                was_moving;
      sample_type          bias;
      sample_type          window_mean;
      logic [VAR_BITS-1:0] window_variance;
   } result_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

endpackage

/* hdl/window_variance_motion_detector_unit.sv */
//  Channel   Direction  Handshake            Payload
//  req_      in         req_push / req_full  req_sample
//  rsp_      out        rsp_pop / rsp_empty  window_full, moving, was_moving, bias,
//                                            window_mean, window_variance
//  csr_      in         csr_write            csr_wdata (variance threshold)
//
// One item is accepted per cycle while req_full is low. An accepted item passes
// the ring read register, the middle queue, the three stages of the statistics
// pipeline and the result queue before its result becomes visible.
// Reset clears the pointers, fill count, running sums, flags, bias and threshold;
// the ring itself is not cleared, since its contents are only used once it is full.
// A stalled result side fills the result queue; once its credits run out the middle
// queue backs up and req_full rises, so no item is ever dropped.
//
// Top level of the window variance motion detector.
// Depends on wvmd_pkg, wvmd_fifo, wvmd_front, wvmd_back and the defines header.
`include "window_variance_motion_detector_unit_defines.svh"

module window_variance_motion_detector_unit #(
   parameter int WINDOW_LOG2 = wvmd_pkg::WINDOW_LOG2_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  wvmd_pkg::sample_type                req_sample,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_window_full,
   output logic                                rsp_moving,
   output logic                                rsp_was_moving,
   output wvmd_pkg::sample_type                rsp_bias,
   output wvmd_pkg::sample_type                rsp_window_mean,
   output logic [wvmd_pkg::VAR_BITS-1:0]       rsp_window_variance,
   input  logic                                csr_write,
   input  logic [wvmd_pkg::THRESH_BITS-1:0]    csr_wdata
);
   import wvmd_pkg::*;

   localparam int ITEM_BITS   = $bits(item_type);
   localparam int RESULT_BITS = $bits(result_type);

   // Variance threshold; users must write it only while idle, which goes unchecked.
   logic [THRESH_BITS-1:0]  threshold_ff, threshold_in;

   logic                    mid_push;
   item_type                mid_item_in;
   item_type                mid_item_out;
   logic [ITEM_BITS-1:0]    mid_data_out;
   logic                    mid_pop;
   fifo_status_type         mid_status;
   logic [MID_CNT_BITS-1:0] mid_count;

   logic                    res_valid;
   result_type              res_in;
   result_type              res_out;
   logic [RESULT_BITS-1:0]  res_data_out;
   fifo_status_type         out_status;
   logic [OUT_CNT_BITS-1:0] out_count;
   logic                    rsp_taken;

   assign threshold_in = csr_write ? csr_wdata : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // The front stores each sample in the ring and pulls out the one it replaces.
   wvmd_front #(
      .WINDOW_LOG2 (WINDOW_LOG2)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_full   (req_full),
      .mid_count  (mid_count),
      .item_valid (mid_push),
      .item       (mid_item_in)
   );

   // Short queue that lets the front keep taking items while the back end waits.
   wvmd_fifo #(
      .DATA_BITS (ITEM_BITS),
      .DEPTH     (MID_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_item_in),
      .pop       (mid_pop),
      .pop_data  (mid_data_out),
      .status    (mid_status),
      .count     (mid_count)
   );

   assign mid_item_out = item_type'(mid_data_out);

   // The back end updates the running sums and makes the motion decision. It only
   // takes an item when the result queue is sure to have room for it.
   wvmd_back #(
      .WINDOW_LOG2 (WINDOW_LOG2)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .threshold   (threshold_ff),
      .item_status (mid_status),
      .item        (mid_item_out),
      .item_pop    (mid_pop),
      .res_taken   (rsp_taken),
      .res_valid   (res_valid),
      .result      (res_in)
   );

   // Result queue; its head drives the result ports directly.
   wvmd_fifo #(
      .DATA_BITS (RESULT_BITS),
      .DEPTH     (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_in),
      .pop       (rsp_pop),
      .pop_data  (res_data_out),
      .status    (out_status),
      .count     (out_count)
   );

   assign res_out             = result_type'(res_data_out);
   assign rsp_empty           = out_status.empty;
   assign rsp_taken           = rsp_pop & ~out_status.empty;
   assign rsp_window_full     = res_out.window_full;
   assign rsp_moving          = res_out.moving;
   assign rsp_was_moving      = res_out.was_moving;
   assign rsp_bias            = res_out.bias;
   assign rsp_window_mean     = res_out.window_mean;
   assign rsp_window_variance = res_out.window_variance;

   // The front must never push into a full middle queue.
   `WVMD_ASSERT_IMP(a_mid_no_overflow, clock, reset, mid_push, !mid_status.full)
   // The credit scheme must keep the result queue from overflowing.
   `WVMD_ASSERT_IMP(a_out_no_overflow, clock, reset, res_valid, (out_count != OUT_CNT_BITS'(OUT_DEPTH)))
   // A result from the filling phase carries no statistics.
   `WVMD_ASSERT_IMP(a_fill_no_stats, clock, reset, (!rsp_empty && !rsp_window_full), (rsp_window_mean == '0 && rsp_window_variance == '0))
   // Reset leaves no result waiting.
   `WVMD_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)

endmodule

/* hdl/wvmd_fifo.sv */
// Small register-based queue used between the stages of the detector.
// Depends on wvmd_pkg for the status type.
module wvmd_fifo #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [DATA_BITS-1:0]          push_data,
   input  logic                          pop,
   output logic [DATA_BITS-1:0]          pop_data,
   output wvmd_pkg::fifo_status_type     status,
   output logic [$clog2(DEPTH+1)-1:0]    count
);
   import wvmd_pkg::*;

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 push_ok;
   logic                 pop_ok;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign count        = count_ff;
   assign pop_data     = store_ff[rd_ptr_ff];
   assign push_ok      = push & ~status.full;
   assign pop_ok       = pop & ~status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/wvmd_front.sv */
// Front end of the detector: sample ring, write pointer and fill count.
// Depends on wvmd_pkg; feeds the middle queue with classified items.
module wvmd_front #(
   parameter int WINDOW_LOG2 = wvmd_pkg::WINDOW_LOG2_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  wvmd_pkg::sample_type                req_sample,
   output logic                                req_full,
   input  logic [wvmd_pkg::MID_CNT_BITS-1:0]   mid_count,
   output logic                                item_valid,
   output wvmd_pkg::item_type                  item
);
   import wvmd_pkg::*;

   localparam int WINDOW = 1 << WINDOW_LOG2;

   sample_type               ring_mem [WINDOW];
   logic [WINDOW_LOG2-1:0]   wp_ff, wp_in;
   logic [WINDOW_LOG2:0]     fill_ff, fill_in;
   logic                     valid_ff, valid_in;
   sample_type               sample_ff;
   sample_type               old_ff;
   logic                     full_ff;
   logic                     accept;
   logic                     ring_full;

   // Room is reserved for the item held in the output register as well.
   assign req_full  = ((MID_CNT_BITS+1)'(mid_count) + (MID_CNT_BITS+1)'(valid_ff))
                      >= (MID_CNT_BITS+1)'(MID_DEPTH);
   assign accept    = req_push & ~req_full;
   assign ring_full = (fill_ff == (WINDOW_LOG2+1)'(WINDOW));

   always_comb begin
      valid_in = accept;
      wp_in    = wp_ff;
      fill_in  = fill_ff;
      if (accept) begin
         wp_in = wp_ff + 1'b1;
         if (!ring_full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         wp_ff    <= '0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         wp_ff    <= wp_in;
         fill_ff  <= fill_in;
      end
   end

   // The ring is read before it is written, so the oldest sample comes out
   // in the same cycle the new one replaces it.
   always_ff @(posedge clock) begin
      if (accept) begin
         ring_mem[wp_ff] <= req_sample;
         old_ff          <= ring_mem[wp_ff];
         sample_ff       <= req_sample;
         full_ff         <= ring_full;
      end
   end

   assign item_valid      = valid_ff;
   assign item.sample     = sample_ff;
   assign item.old_sample = old_ff;
   assign item.full       = full_ff;

endmodule

/* hdl/wvmd_back.sv */
// Back end of the detector: running sums, variance and motion decision.
// Depends on wvmd_pkg; reads the middle queue and writes the result queue.
module wvmd_back #(
   parameter int WINDOW_LOG2 = wvmd_pkg::WINDOW_LOG2_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [wvmd_pkg::THRESH_BITS-1:0]    threshold,
   input  wvmd_pkg::fifo_status_type           item_status,
   input  wvmd_pkg::item_type                  item,
   output logic                                item_pop,
   input  logic                                res_taken,
   output logic                                res_valid,
   output wvmd_pkg::result_type                result
);
   import wvmd_pkg::*;

   localparam int SUM_BITS = SAMPLE_BITS + WINDOW_LOG2;
   localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
   localparam int SSQ_BITS = SQ_BITS + WINDOW_LOG2;
   localparam int NUM_BITS = 2 * SUM_BITS - 1;

   // Credits cover every item popped but not yet taken from the result queue.
   logic [OUT_CNT_BITS-1:0]      credit_ff, credit_in;

   logic signed [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [SSQ_BITS-1:0]          ssq_ff, ssq_in;

   logic                         s1_valid_ff;
   logic                         s1_full_ff;
   logic signed [SUM_BITS-1:0]   s1_sum_ff;
   logic [SQ_BITS-1:0]           s1_sq_new_ff, s1_sq_new_in;
   logic [SQ_BITS-1:0]           s1_sq_old_ff, s1_sq_old_in;

   logic                         s2_valid_ff;
   logic                         s2_full_ff;
   logic signed [SUM_BITS-1:0]   s2_sum_ff;
   logic [SSQ_BITS-1:0]          s2_ssq_ff;
   logic [NUM_BITS-1:0]          s2_sum_sq_ff, s2_sum_sq_in;

   logic                         s3_valid_ff;
   logic                         s3_full_ff;
   sample_type                   s3_mean_ff, s3_mean_in;
   logic [VAR_BITS-1:0]          s3_var_ff, s3_var_in;

   logic                         motion_ff, motion_in;
   logic                         prev_motion_ff, prev_motion_in;
   sample_type                   bias_ff, bias_in;

   logic signed [SUM_BITS-1:0]   new_ext;
   logic signed [SUM_BITS-1:0]   old_ext;
   logic signed [2*SAMPLE_BITS-1:0] prod_new;
   logic signed [2*SAMPLE_BITS-1:0] prod_old;
   logic signed [2*SUM_BITS-1:0] sum_prod;
   logic [NUM_BITS-1:0]          scaled_ssq;
   logic [NUM_BITS-1:0]          numer;
   logic                         still;

   assign item_pop = ~item_status.empty & (credit_ff < OUT_CNT_BITS'(OUT_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (item_pop && !res_taken) begin
         credit_in = credit_ff + 1'b1;
      end else if (res_taken && !item_pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   // Stage 1: running sum and the two squares.
   assign new_ext  = SUM_BITS'($signed(item.sample));
   assign old_ext  = item.full ? SUM_BITS'($signed(item.old_sample)) : '0;
   assign prod_new = $signed(item.sample) * $signed(item.sample);
   assign prod_old = $signed(item.old_sample) * $signed(item.old_sample);
   assign sum_in   = item_pop ? sum_ff + new_ext - old_ext : sum_ff;
   assign s1_sq_new_in = prod_new[SQ_BITS-1:0];
   assign s1_sq_old_in = item.full ? prod_old[SQ_BITS-1:0] : '0;

   // Stage 2: running sum of squares and the square of the sum.
   assign ssq_in = s1_valid_ff ? ssq_ff + SSQ_BITS'(s1_sq_new_ff) - SSQ_BITS'(s1_sq_old_ff)
                               : ssq_ff;
   assign sum_prod     = s1_sum_ff * s1_sum_ff;
   assign s2_sum_sq_in = sum_prod[NUM_BITS-1:0];

   // Stage 3: mean, and variance numerator over the window size squared.
   assign scaled_ssq = {s2_ssq_ff, {WINDOW_LOG2{1'b0}}};
   assign numer      = (scaled_ssq >= s2_sum_sq_ff) ? scaled_ssq - s2_sum_sq_ff : '0;
   assign s3_var_in  = s2_full_ff ? numer[NUM_BITS-1:2*WINDOW_LOG2] : '0;
   assign s3_mean_in = s2_full_ff ? s2_sum_ff[SUM_BITS-1:WINDOW_LOG2] : '0;

   // Final step: the motion decision goes straight into the result queue.
   assign still = (s3_var_ff < threshold);

   always_comb begin
      motion_in      = motion_ff;
      prev_motion_in = prev_motion_ff;
      bias_in        = bias_ff;
      if (s3_valid_ff && s3_full_ff) begin
         prev_motion_in = motion_ff;
         motion_in      = ~still;
         if (still) begin
            bias_in = s3_mean_ff;
         end
      end
   end

   assign res_valid              = s3_valid_ff;
   assign result.window_full     = s3_full_ff;
   assign result.moving          = motion_in;
   assign result.was_moving      = prev_motion_in;
   assign result.bias            = bias_in;
   assign result.window_mean     = s3_mean_ff;
   assign result.window_variance = s3_var_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff      <= '0;
         sum_ff         <= '0;
         ssq_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         motion_ff      <= 1'b0;
         prev_motion_ff <= 1'b0;
         bias_ff        <= '0;
      end else begin
         credit_ff      <= credit_in;
         sum_ff         <= sum_in;
         ssq_ff         <= ssq_in;
         s1_valid_ff    <= item_pop;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         motion_ff      <= motion_in;
         prev_motion_ff <= prev_motion_in;
         bias_ff        <= bias_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_full_ff   <= item.full;
      s1_sum_ff    <= sum_in;
      s1_sq_new_ff <= s1_sq_new_in;
      s1_sq_old_ff <= s1_sq_old_in;
      s2_full_ff   <= s1_full_ff;
      s2_sum_ff    <= s1_sum_ff;
      s2_ssq_ff    <= ssq_in;
      s2_sum_sq_ff <= s2_sum_sq_in;
      s3_full_ff   <= s2_full_ff;
      s3_mean_ff   <= s3_mean_in;
      s3_var_ff    <= s3_var_in;
   end

endmodule
